[hw/rtl/vkl_pkg.sv]
// Shared types and constants of the key period estimator.
package vkl_pkg;

  localparam int unsigned MAX_LETTERS = 4096;
  localparam logic [4:0]  MAX_PERIOD  = 5'd20;
  localparam int unsigned ALPHABET    = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] LETTER_FIRST = 8'd192;
  localparam logic [7:0] LETTER_LAST  = 8'd223;

  localparam logic [4:0] NO_PERIOD = 5'd1;

  localparam logic [6:0] IC_LOW_RESET  = 7'd20;
  localparam logic [6:0] IC_HIGH_RESET = 7'd25;
  localparam logic [4:0] MIN_P_RESET   = 5'd3;
  localparam logic [4:0] MAX_P_RESET   = 5'd20;

  localparam logic [1:0] CFG_IC_LOW  = 2'd0;
  localparam logic [1:0] CFG_IC_HIGH = 2'd1;
  localparam logic [1:0] CFG_MIN_P   = 2'd2;
  localparam logic [1:0] CFG_MAX_P   = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } vkl_in_t;

  typedef struct packed {
    logic [4:0] key_period;
    logic       overflowed;
  } vkl_out_t;

  typedef struct packed {
    logic       is_letter;
    logic [4:0] letter;
    logic       is_last;
  } vkl_entry_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PSTART,
    ST_DIV,
    ST_GSTART,
    ST_SCAN,
    ST_SUM,
    ST_SUMF,
    ST_MUL,
    ST_CMP,
    ST_RESULT
  } vkl_state_e;

endpackage

[hw/rtl/vigenere_key_length_ic.sv]
// Top level of the key period estimator based on the index of coincidence.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o   in_data_i (text_byte, is_last)
//   out       output     out_valid_o / out_stall_i out_data_o (key_period, overflowed)
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Bytes are taken at one per cycle while the message loads into the letter store.
// After the last byte the search runs per period a serial division for the quotient and
// remainder, then per residue group a scan of the group's stored letters, paced by the
// single read port of the letter store, and a sweep of the 32-bin histogram.
// During the search the queue fills and input stalls; the store needs no clearing
// pass after reset. A waiting result does not block loading of the next message.
module vigenere_key_length_ic #(
  parameter int unsigned MaxLetters = vkl_pkg::MAX_LETTERS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vkl_pkg::vkl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output vkl_pkg::vkl_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [6:0]        cfg_wdata_i
);
  import vkl_pkg::*;

  logic       push, pop, q_full, q_empty;
  vkl_entry_t push_entry, pop_entry;

  vkl_front u_front (
    .need_unused_i(1'b0),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  vkl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .empty_o(q_empty)
  );

  vkl_back #(
    .MaxLetters(MaxLetters)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .entry_i    (pop_entry),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

[hw/rtl/vkl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module vkl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/vkl_front.sv]
// Input side: accepts bytes and classifies each one into a queue entry.
module vkl_front (
  input  logic                need_unused_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vkl_pkg::vkl_in_t    in_data_i,
  input  logic                q_full_i,
  output logic                push_o,
  output vkl_pkg::vkl_entry_t entry_o
);
  import vkl_pkg::*;

  logic is_letter;

  assign is_letter = (in_data_i.text_byte >= LETTER_FIRST) &&
                     (in_data_i.text_byte <= LETTER_LAST);

  assign in_stall_o = q_full_i | need_unused_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    entry_o.is_letter = is_letter;
    entry_o.letter    = 5'(in_data_i.text_byte - LETTER_FIRST);
    entry_o.is_last   = in_data_i.is_last;
  end

endmodule

[hw/rtl/vkl_queue.sv]
// Short queue that decouples the input side from the analysis side.
module vkl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vkl_pkg::vkl_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output vkl_pkg::vkl_entry_t entry_o,
  output logic                empty_o
);
  import vkl_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

  vkl_entry_t   slot_q [QUEUE_DEPTH];
  logic [QAW:0] wr_ptr_q, wr_ptr_d;
  logic [QAW:0] rd_ptr_q, rd_ptr_d;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[QAW] != rd_ptr_q[QAW]) &&
                   (wr_ptr_q[QAW-1:0] == rd_ptr_q[QAW-1:0]);
  assign entry_o = slot_q[rd_ptr_q[QAW-1:0]];

  assign wr_ptr_d = wr_ptr_q + (QAW+1)'(push_i);
  assign rd_ptr_d = rd_ptr_q + (QAW+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q[QAW-1:0]] <= entry_i;
    end
  end

endmodule

[hw/rtl/vkl_back.sv]
// Analysis side: stores letters, runs the coincidence period search, holds the result.
module vkl_back #(
  parameter int unsigned MaxLetters = vkl_pkg::MAX_LETTERS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [6:0]          cfg_wdata_i,
  input  vkl_pkg::vkl_entry_t entry_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vkl_pkg::vkl_out_t   out_data_o
);
  import vkl_pkg::*;

  localparam int unsigned AW   = $clog2(MaxLetters);
  localparam int unsigned LCW  = $clog2(MaxLetters + 1);
  localparam int unsigned POSW = $clog2(MaxLetters + 32);
  localparam int unsigned SW   = 2 * LCW;
  localparam int unsigned DW   = 30;
  localparam int unsigned LW   = DW + 7;
  localparam int unsigned CW   = (SW + 7 > LW) ? SW + 7 : LW;

  vkl_state_e state_q, state_d;

  logic [6:0] low_q, high_q;
  logic [4:0] minp_q, maxp_q;

  logic [15:0]     byte_cnt_q, byte_cnt_d;
  logic [LCW-1:0]  letter_cnt_q, letter_cnt_d;
  logic            ovf_q, ovf_d;
  logic [5:0]      p_q, p_d;
  logic [4:0]      j_q, j_d;
  logic [14:0]     div_q, div_d;
  logic [4:0]      rem_q, rem_d;
  logic [3:0]      step_q, step_d;
  logic [14:0]     n_q, n_d;
  logic [POSW-1:0] pos_q, pos_d;
  logic            rd_pend_q, rd_pend_d;
  logic [4:0]      b_q, b_d;
  logic [SW-1:0]   prod_q, prod_d;
  logic            prod_vld_q, prod_vld_d;
  logic [SW-1:0]   acc_q, acc_d;
  logic [DW-1:0]   d_q, d_d;
  logic [CW-1:0]   lo_q, lo_d, hi_q, hi_d, s100_q, s100_d;
  logic [4:0]      res_q, res_d;
  logic            out_valid_q, out_valid_d;
  vkl_out_t        out_q, out_d;

  logic [LCW-1:0]  bin_q [ALPHABET];
  logic [ALPHABET-1:0] bin_vld_q;
  logic            bin_clr, bin_inc;
  logic [4:0]      bin_idx;
  logic [LCW-1:0]  bin_cur;

  logic            ram_we, ram_re;
  logic [4:0]      ram_rdata;
  logic [4:0]      top;
  logic [5:0]      trial;
  logic            ge;
  logic            issue;
  logic            pass;

  vkl_ram #(
    .Width(5),
    .Depth(MaxLetters)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(letter_cnt_q[AW-1:0]),
    .wdata_i(entry_i.letter),
    .re_i   (ram_re),
    .raddr_i(pos_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= IC_LOW_RESET;
      high_q <= IC_HIGH_RESET;
      minp_q <= MIN_P_RESET;
      maxp_q <= MAX_P_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IC_LOW:  low_q  <= cfg_wdata_i;
        CFG_IC_HIGH: high_q <= cfg_wdata_i;
        CFG_MIN_P:   minp_q <= cfg_wdata_i[4:0];
        CFG_MAX_P:   maxp_q <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  assign top     = (maxp_q > MAX_PERIOD) ? MAX_PERIOD : maxp_q;
  assign trial   = {rem_q, div_q[14]};
  assign ge      = (trial >= p_q);
  assign issue   = (pos_q < POSW'(letter_cnt_q));
  assign bin_idx = (state_q == ST_SCAN) ? ram_rdata : b_q;
  assign bin_cur = bin_vld_q[bin_idx] ? bin_q[bin_idx] : '0;
  assign pass    = (d_q != '0) && (lo_q <= s100_q) && (s100_q <= hi_q);

  always_comb begin
    state_d      = state_q;
    byte_cnt_d   = byte_cnt_q;
    letter_cnt_d = letter_cnt_q;
    ovf_d        = ovf_q;
    p_d          = p_q;
    j_d          = j_q;
    div_d        = div_q;
    rem_d        = rem_q;
    step_d       = step_q;
    n_d          = n_q;
    pos_d        = pos_q;
    rd_pend_d    = 1'b0;
    b_d          = b_q;
    prod_d       = prod_q;
    prod_vld_d   = prod_vld_q;
    acc_d        = acc_q;
    d_d          = d_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    s100_d       = s100_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & out_stall_i;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    bin_clr      = 1'b0;
    bin_inc      = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (byte_cnt_q != 16'hFFFF) begin
            byte_cnt_d = byte_cnt_q + 16'd1;
          end
          if (entry_i.is_letter) begin
            if (letter_cnt_q < LCW'(MaxLetters)) begin
              ram_we       = 1'b1;
              letter_cnt_d = letter_cnt_q + LCW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (entry_i.is_last) begin
            p_d     = {1'b0, minp_q};
            state_d = ST_PSTART;
          end
        end
      end
      ST_PSTART: begin
        if (p_q > {1'b0, top}) begin
          res_d   = NO_PERIOD;
          state_d = ST_RESULT;
        end else if (p_q == '0) begin
          p_d = p_q + 6'd1;
        end else begin
          div_d   = byte_cnt_q[15:1];
          rem_d   = '0;
          step_d  = '0;
          j_d     = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? 5'(trial - p_q) : trial[4:0];
        div_d  = {div_q[13:0], ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd14) begin
          state_d = ST_GSTART;
        end
      end
      ST_GSTART: begin
        n_d        = 15'(16'(div_q) + 16'(j_q < rem_q));
        pos_d      = POSW'(j_q);
        bin_clr    = 1'b1;
        acc_d      = '0;
        prod_vld_d = 1'b0;
        b_d        = '0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) begin
          ram_re    = 1'b1;
          pos_d     = pos_q + POSW'(p_q);
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          bin_inc = 1'b1;
        end
        if (!issue && !rd_pend_q) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        prod_d     = (bin_cur == '0) ? '0 : SW'(bin_cur) * SW'(bin_cur - LCW'(1));
        prod_vld_d = 1'b1;
        if (prod_vld_q) begin
          acc_d = acc_q + prod_q;
        end
        b_d = b_q + 5'd1;
        if (b_q == 5'd31) begin
          state_d = ST_SUMF;
        end
      end
      ST_SUMF: begin
        acc_d      = acc_q + prod_q;
        prod_vld_d = 1'b0;
        d_d        = (n_q == '0) ? '0 : DW'(n_q) * DW'(n_q - 15'd1);
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        lo_d    = CW'(LW'(low_q) * LW'(d_q));
        hi_d    = CW'(LW'(high_q) * LW'(d_q));
        s100_d  = CW'(acc_q) * CW'(100);
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (pass && (p_q > {1'b0, minp_q})) begin
          res_d   = p_q[4:0];
          state_d = ST_RESULT;
        end else if (pass || (j_q == 5'(p_q - 6'd1))) begin
          p_d     = p_q + 6'd1;
          state_d = ST_PSTART;
        end else begin
          j_d     = j_q + 5'd1;
          state_d = ST_GSTART;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.key_period = res_q;
          out_d.overflowed = ovf_q;
          out_valid_d      = 1'b1;
          byte_cnt_d       = '0;
          letter_cnt_d     = '0;
          ovf_d            = 1'b0;
          state_d          = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      byte_cnt_q   <= '0;
      letter_cnt_q <= '0;
      ovf_q        <= 1'b0;
      rd_pend_q    <= 1'b0;
      prod_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      bin_vld_q    <= '0;
    end else begin
      state_q      <= state_d;
      byte_cnt_q   <= byte_cnt_d;
      letter_cnt_q <= letter_cnt_d;
      ovf_q        <= ovf_d;
      rd_pend_q    <= rd_pend_d;
      prod_vld_q   <= prod_vld_d;
      out_valid_q  <= out_valid_d;
      if (bin_clr) begin
        bin_vld_q <= '0;
      end else if (bin_inc) begin
        bin_vld_q[bin_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    j_q    <= j_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    n_q    <= n_d;
    pos_q  <= pos_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    d_q    <= d_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    s100_q <= s100_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (bin_inc) begin
      bin_q[bin_idx] <= bin_cur + LCW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
